// ===== design/ipgm_pkg.sv =====
// ----------------------------------------------------------------------------
// ipgm_pkg
// Shared types and constants for the inverse perspective ground mapper.
// ----------------------------------------------------------------------------
package ipgm_pkg;

    // pixel coordinate width at the ports
    localparam int COORD_W = 12;
    // signed pixel offset from the principal point
    localparam int DU_W    = COORD_W + 1;
    // ray component, signed Q.32
    localparam int D_W     = DU_W + 32;
    // ray component magnitude
    localparam int MAG_W   = D_W - 1;
    localparam int MAG_LO  = MAG_W / 2;
    localparam int MAG_HI  = MAG_W - MAG_LO;
    // cos * |d1| partial products
    localparam int TP_W    = 17 + MAG_HI;
    localparam int TS_W    = 17 + MAG_W;
    localparam int T_W     = TS_W - 16;
    // ground denominator, signed Q.32
    localparam int DEN_W   = T_W + 2;
    localparam int REM_W   = DEN_W - 1;
    // saturated depth quotient width
    localparam int Q_W     = 31;
    // depth * magnitude partial products
    localparam int PP_W    = Q_W + MAG_HI;
    localparam int PS_W    = Q_W + MAG_W;
    localparam int P_W     = PS_W - 32;

    localparam logic [Q_W-1:0] Z_SAT = {Q_W{1'b1}};

    // register indexes of the configuration port
    typedef enum logic [3:0] {
        REG_INV_FOCAL    = 4'd0,
        REG_CENTER_X     = 4'd1,
        REG_CENTER_Y     = 4'd2,
        REG_COS_PITCH    = 4'd3,
        REG_SIN_PITCH    = 4'd4,
        REG_CAM_HEIGHT   = 4'd5,
        REG_WHITE_THRESH = 4'd6,
        REG_MAX_DISTANCE = 4'd7
    } ipgm_reg_t;

    // result status
    typedef enum logic [1:0] {
        ST_NOT_WHITE = 2'd0,
        ST_NO_HIT    = 2'd1,
        ST_TOO_FAR   = 2'd2,
        ST_VALID     = 2'd3
    } ipgm_status_t;

    typedef struct packed {
        logic [31:0]        inv_focal;
        logic [11:0]        center_x;
        logic [11:0]        center_y;
        logic [16:0]        cos_pitch;
        logic signed [17:0] sin_pitch;
        logic [23:0]        camera_height;
        logic [7:0]         white_min;
        logic [30:0]        max_distance;
    } ipgm_cfg_t;

    // per-pixel side data carried alongside the divider
    typedef struct packed {
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
        logic               white;
        logic               hit;
        logic               ovf;
        logic               d0_neg;
        logic [MAG_W-1:0]   d0_mag;
        logic               d1_neg;
        logic [MAG_W-1:0]   d1_mag;
    } ipgm_tag_t;

endpackage

// ===== design/ipgm_front.sv =====
// ----------------------------------------------------------------------------
// ipgm_front
// White test, ray forming and ground denominator, five register stages.
// ----------------------------------------------------------------------------
module ipgm_front #(
    parameter int MAX_CHANNELS = 4,
    parameter int COORD_BITS   = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [ipgm_pkg::COORD_W-1:0]        pixel_u,
    input  logic [ipgm_pkg::COORD_W-1:0]        pixel_v,
    input  logic [7:0]                          chan [4],
    input  logic [2:0]                          channel_count,
    input  ipgm_pkg::ipgm_cfg_t                 cfg,
    output logic                                out_valid,
    output ipgm_pkg::ipgm_tag_t                 out_tag,
    output logic [ipgm_pkg::REM_W-1:0]          out_rem,
    output logic [ipgm_pkg::REM_W-1:0]          out_denom
);
    import ipgm_pkg::*;

    localparam int CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((32'd1 << CW) - 32'd1);
    localparam logic [2:0] CH_MAX = 3'(MAX_CHANNELS);

    logic [4:0] vld_reg;

    // stage 1: mask, white test, offsets
    logic [COORD_W-1:0]    s1_u_reg, s1_v_reg;
    logic                  s1_white_reg;
    logic signed [DU_W-1:0] s1_du_reg, s1_dv_reg;
    logic [COORD_W-1:0]    u_m, v_m;
    logic [2:0]            cnt_eff;
    logic                  white_next;

    always_comb
    begin
        u_m = pixel_u & COORD_MASK;
        v_m = pixel_v & COORD_MASK;
        cnt_eff = (channel_count > CH_MAX) ? CH_MAX : channel_count;
        white_next = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            if ((3'(i) < cnt_eff) && (chan[i] < cfg.white_min))
            begin
                white_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_u_reg     <= u_m;
            s1_v_reg     <= v_m;
            s1_white_reg <= white_next;
            s1_du_reg    <= $signed({1'b0, u_m}) - $signed({1'b0, cfg.center_x & COORD_MASK});
            s1_dv_reg    <= $signed({1'b0, v_m}) - $signed({1'b0, cfg.center_y & COORD_MASK});
        end
    end

    // stage 2: ray components, offset times 1/f
    logic [COORD_W-1:0]    s2_u_reg, s2_v_reg;
    logic                  s2_white_reg;
    logic signed [D_W-1:0] s2_d0_reg, s2_d1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_u_reg     <= s1_u_reg;
            s2_v_reg     <= s1_v_reg;
            s2_white_reg <= s1_white_reg;
            s2_d0_reg    <= s1_du_reg * $signed({1'b0, cfg.inv_focal});
            s2_d1_reg    <= s1_dv_reg * $signed({1'b0, cfg.inv_focal});
        end
    end

    // stage 3: magnitudes, cos * |d1| in two halves
    logic [COORD_W-1:0] s3_u_reg, s3_v_reg;
    logic               s3_white_reg;
    logic               s3_d0_neg_reg, s3_d1_neg_reg;
    logic [MAG_W-1:0]   s3_d0_mag_reg, s3_d1_mag_reg;
    logic [TP_W-1:0]    s3_tl_reg, s3_th_reg;
    logic [MAG_W-1:0]   m0, m1;

    always_comb
    begin
        m0 = s2_d0_reg[D_W-1] ? MAG_W'(-s2_d0_reg) : MAG_W'(s2_d0_reg);
        m1 = s2_d1_reg[D_W-1] ? MAG_W'(-s2_d1_reg) : MAG_W'(s2_d1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_u_reg      <= s2_u_reg;
            s3_v_reg      <= s2_v_reg;
            s3_white_reg  <= s2_white_reg;
            s3_d0_neg_reg <= s2_d0_reg[D_W-1];
            s3_d1_neg_reg <= s2_d1_reg[D_W-1];
            s3_d0_mag_reg <= m0;
            s3_d1_mag_reg <= m1;
            s3_tl_reg     <= TP_W'(cfg.cos_pitch * m1[MAG_LO-1:0]);
            s3_th_reg     <= TP_W'(cfg.cos_pitch * m1[MAG_W-1:MAG_LO]);
        end
    end

    // stage 4: denominator = +-trunc(cos*|d1|/2^16) + sin*2^16
    logic [COORD_W-1:0]       s4_u_reg, s4_v_reg;
    logic                     s4_white_reg;
    logic                     s4_d0_neg_reg, s4_d1_neg_reg;
    logic [MAG_W-1:0]         s4_d0_mag_reg, s4_d1_mag_reg;
    logic signed [DEN_W-1:0]  s4_den_reg;
    logic [TS_W-1:0]          tsum;
    logic [T_W-1:0]           t_val;
    logic signed [DEN_W-1:0]  t_sgn, sin_ext;

    always_comb
    begin
        tsum    = TS_W'(s3_tl_reg) + {s3_th_reg, {MAG_LO{1'b0}}};
        t_val   = tsum[TS_W-1:16];
        t_sgn   = $signed({2'b00, t_val});
        sin_ext = $signed({{(DEN_W-34){cfg.sin_pitch[17]}}, cfg.sin_pitch, 16'h0000});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_u_reg      <= s3_u_reg;
            s4_v_reg      <= s3_v_reg;
            s4_white_reg  <= s3_white_reg;
            s4_d0_neg_reg <= s3_d0_neg_reg;
            s4_d1_neg_reg <= s3_d1_neg_reg;
            s4_d0_mag_reg <= s3_d0_mag_reg;
            s4_d1_mag_reg <= s3_d1_mag_reg;
            s4_den_reg    <= (s3_d1_neg_reg ? -t_sgn : t_sgn) + sin_ext;
        end
    end

    // stage 5: ground hit, quotient overflow, divider start
    logic [REM_W-1:0] h2;
    logic             hit_c;

    always_comb
    begin
        h2    = REM_W'({cfg.camera_height, 1'b0});
        hit_c = !s4_den_reg[DEN_W-1] && (s4_den_reg[REM_W-1:0] > REM_W'(1));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_tag.u      <= s4_u_reg;
            out_tag.v      <= s4_v_reg;
            out_tag.white  <= s4_white_reg;
            out_tag.hit    <= hit_c;
            out_tag.ovf    <= h2 >= s4_den_reg[REM_W-1:0];
            out_tag.d0_neg <= s4_d0_neg_reg;
            out_tag.d0_mag <= s4_d0_mag_reg;
            out_tag.d1_neg <= s4_d1_neg_reg;
            out_tag.d1_mag <= s4_d1_mag_reg;
            out_rem        <= h2;
            out_denom      <= s4_den_reg[REM_W-1:0];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    assign out_valid = vld_reg[4];

endmodule

// ===== design/ipgm_div_stage.sv =====
// ----------------------------------------------------------------------------
// ipgm_div_stage
// One restoring division step: one quotient bit per register stage.
// ----------------------------------------------------------------------------
module ipgm_div_stage (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [ipgm_pkg::REM_W-1:0]   in_rem,
    input  logic [ipgm_pkg::REM_W-1:0]   in_denom,
    input  logic [ipgm_pkg::Q_W-1:0]     in_q,
    input  ipgm_pkg::ipgm_tag_t          in_tag,
    output logic                         out_valid,
    output logic [ipgm_pkg::REM_W-1:0]   out_rem,
    output logic [ipgm_pkg::REM_W-1:0]   out_denom,
    output logic [ipgm_pkg::Q_W-1:0]     out_q,
    output ipgm_pkg::ipgm_tag_t          out_tag
);
    import ipgm_pkg::*;

    logic [REM_W:0] r2, diff;
    logic           ge;

    // shift in a zero numerator bit, compare and subtract
    always_comb
    begin
        r2   = {in_rem, 1'b0};
        diff = r2 - {1'b0, in_denom};
        ge   = r2 >= {1'b0, in_denom};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_rem   <= ge ? diff[REM_W-1:0] : r2[REM_W-1:0];
            out_denom <= in_denom;
            out_q     <= {in_q[Q_W-2:0], ge};
            out_tag   <= in_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= in_valid;
        end
    end

endmodule

// ===== design/ipgm_back.sv =====
// ----------------------------------------------------------------------------
// ipgm_back
// Depth saturation, status and X/Y scaling, three stages incl. output register.
// ----------------------------------------------------------------------------
module ipgm_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ipgm_pkg::Q_W-1:0]    in_q,
    input  ipgm_pkg::ipgm_tag_t         in_tag,
    input  ipgm_pkg::ipgm_cfg_t         cfg,
    output logic                        out_valid,
    output logic [ipgm_pkg::COORD_W-1:0] out_u,
    output logic [ipgm_pkg::COORD_W-1:0] out_v,
    output logic [1:0]                  status,
    output logic signed [31:0]          x_m,
    output logic signed [31:0]          y_m,
    output logic signed [31:0]          z_m
);
    import ipgm_pkg::*;

    logic [2:0] vld_reg;

    // stage A: saturated depth, status, partial products
    logic [COORD_W-1:0] a_u_reg, a_v_reg;
    ipgm_status_t       a_st_reg;
    logic [Q_W-1:0]     a_zs_reg;
    logic               a_n0_reg, a_n1_reg;
    logic [PP_W-1:0]    a_pl0_reg, a_ph0_reg, a_pl1_reg, a_ph1_reg;
    logic [Q_W-1:0]     zs;
    ipgm_status_t       st_next;

    always_comb
    begin
        zs = in_tag.ovf ? Z_SAT : in_q;
        if (!in_tag.white)
        begin
            st_next = ST_NOT_WHITE;
        end
        else if (!in_tag.hit)
        begin
            st_next = ST_NO_HIT;
        end
        else if (in_tag.ovf || (zs > cfg.max_distance))
        begin
            st_next = ST_TOO_FAR;
        end
        else
        begin
            st_next = ST_VALID;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_u_reg   <= in_tag.u;
            a_v_reg   <= in_tag.v;
            a_st_reg  <= st_next;
            a_zs_reg  <= zs;
            a_n0_reg  <= in_tag.d0_neg;
            a_n1_reg  <= in_tag.d1_neg;
            a_pl0_reg <= PP_W'(zs * in_tag.d0_mag[MAG_LO-1:0]);
            a_ph0_reg <= PP_W'(zs * in_tag.d0_mag[MAG_W-1:MAG_LO]);
            a_pl1_reg <= PP_W'(zs * in_tag.d1_mag[MAG_LO-1:0]);
            a_ph1_reg <= PP_W'(zs * in_tag.d1_mag[MAG_W-1:MAG_LO]);
        end
    end

    // stage B: sum partial products, drop 32 fraction bits
    logic [COORD_W-1:0] b_u_reg, b_v_reg;
    ipgm_status_t       b_st_reg;
    logic [Q_W-1:0]     b_zs_reg;
    logic               b_n0_reg, b_n1_reg;
    logic [P_W-1:0]     b_p0_reg, b_p1_reg;
    logic [PS_W-1:0]    sum0, sum1;

    always_comb
    begin
        sum0 = PS_W'(a_pl0_reg) + {a_ph0_reg, {MAG_LO{1'b0}}};
        sum1 = PS_W'(a_pl1_reg) + {a_ph1_reg, {MAG_LO{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_u_reg  <= a_u_reg;
            b_v_reg  <= a_v_reg;
            b_st_reg <= a_st_reg;
            b_zs_reg <= a_zs_reg;
            b_n0_reg <= a_n0_reg;
            b_n1_reg <= a_n1_reg;
            b_p0_reg <= sum0[PS_W-1:32];
            b_p1_reg <= sum1[PS_W-1:32];
        end
    end

    // stage C: sign, saturate, blank on no result
    function automatic logic [31:0] sat_coord(input logic neg, input logic [P_W-1:0] p);
        logic [31:0] mag;
        begin
            if (neg)
            begin
                mag = (p > P_W'(32'h8000_0000)) ? 32'h8000_0000 : p[31:0];
                sat_coord = -mag;
            end
            else
            begin
                sat_coord = (p > P_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : p[31:0];
            end
        end
    endfunction

    logic blank;
    assign blank = (b_st_reg == ST_NOT_WHITE) || (b_st_reg == ST_NO_HIT);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_u  <= b_u_reg;
            out_v  <= b_v_reg;
            status <= b_st_reg;
            x_m    <= blank ? 32'sd0 : $signed(sat_coord(b_n0_reg, b_p0_reg));
            y_m    <= blank ? 32'sd0 : $signed(sat_coord(b_n1_reg, b_p1_reg));
            z_m    <= blank ? 32'sd0 : $signed({1'b0, b_zs_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    assign out_valid = vld_reg[2];

endmodule

// ===== design/inverse_perspective_ground_map.sv =====
// ----------------------------------------------------------------------------
// inverse_perspective_ground_map
// Maps white pixels onto a flat ground plane seen by a pitched camera.
// ----------------------------------------------------------------------------
// Fully pipelined: one pixel per clock while the output is not stalled. Five
// front stages form the ray and ground denominator, 31 restoring division
// stages produce the depth one quotient bit each, and three back stages scale
// X and Y and hold the output register. The whole pipe advances whenever the
// output register is empty or being taken. Configuration writes take effect
// at once and must only be made while no pixel is in flight.
module inverse_perspective_ground_map #(
    parameter int MAX_CHANNELS = 4,
    parameter int COORD_BITS   = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [3:0]                   cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ipgm_pkg::COORD_W-1:0] pixel_u,
    input  logic [ipgm_pkg::COORD_W-1:0] pixel_v,
    input  logic [7:0]                   chan0,
    input  logic [7:0]                   chan1,
    input  logic [7:0]                   chan2,
    input  logic [7:0]                   chan3,
    input  logic [2:0]                   channel_count,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ipgm_pkg::COORD_W-1:0] out_u,
    output logic [ipgm_pkg::COORD_W-1:0] out_v,
    output logic [1:0]                   status,
    output logic signed [31:0]           x_m,
    output logic signed [31:0]           y_m,
    output logic signed [31:0]           z_m
);
    import ipgm_pkg::*;

    ipgm_cfg_t  cfg_reg;
    logic       en;
    logic [7:0] chan [4];

    assign cfg_ready = 1'b1;
    assign en        = !out_valid || out_ready;
    assign in_ready  = en;
    assign chan[0]   = chan0;
    assign chan[1]   = chan1;
    assign chan[2]   = chan2;
    assign chan[3]   = chan3;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_focal       <= 32'd3976822;
            cfg_reg.center_x        <= 12'd960;
            cfg_reg.center_y        <= 12'd540;
            cfg_reg.cos_pitch       <= 17'd63303;
            cfg_reg.sin_pitch       <= 18'sd16962;
            cfg_reg.camera_height   <= 24'd111411;
            cfg_reg.white_min       <= 8'd200;
            cfg_reg.max_distance    <= 31'd13107200;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_INV_FOCAL:    cfg_reg.inv_focal       <= cfg_data;
                REG_CENTER_X:     cfg_reg.center_x        <= cfg_data[11:0];
                REG_CENTER_Y:     cfg_reg.center_y        <= cfg_data[11:0];
                REG_COS_PITCH:    cfg_reg.cos_pitch       <= cfg_data[16:0];
                REG_SIN_PITCH:    cfg_reg.sin_pitch       <= $signed(cfg_data[17:0]);
                REG_CAM_HEIGHT:   cfg_reg.camera_height   <= cfg_data[23:0];
                REG_WHITE_THRESH: cfg_reg.white_min       <= cfg_data[7:0];
                REG_MAX_DISTANCE: cfg_reg.max_distance    <= cfg_data[30:0];
                default:          ;
            endcase
        end
    end

    // front end
    logic                 dv   [Q_W+1];
    logic [REM_W-1:0]     drem [Q_W+1];
    logic [REM_W-1:0]     dden [Q_W+1];
    logic [Q_W-1:0]       dq   [Q_W+1];
    ipgm_tag_t            dtag [Q_W+1];

    ipgm_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .COORD_BITS   (COORD_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (in_valid),
        .pixel_u       (pixel_u),
        .pixel_v       (pixel_v),
        .chan          (chan),
        .channel_count (channel_count),
        .cfg           (cfg_reg),
        .out_valid     (dv[0]),
        .out_tag       (dtag[0]),
        .out_rem       (drem[0]),
        .out_denom     (dden[0])
    );

    assign dq[0] = '0;

    // depth divider, one bit per stage
    for (genvar k = 0; k < Q_W; k++)
    begin : g_div
        ipgm_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv[k]),
            .in_rem    (drem[k]),
            .in_denom  (dden[k]),
            .in_q      (dq[k]),
            .in_tag    (dtag[k]),
            .out_valid (dv[k+1]),
            .out_rem   (drem[k+1]),
            .out_denom (dden[k+1]),
            .out_q     (dq[k+1]),
            .out_tag   (dtag[k+1])
        );
    end

    // back end and output register
    ipgm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv[Q_W]),
        .in_q      (dq[Q_W]),
        .in_tag    (dtag[Q_W]),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_u     (out_u),
        .out_v     (out_v),
        .status    (status),
        .x_m       (x_m),
        .y_m       (y_m),
        .z_m       (z_m)
    );

`ifndef SYNTHESIS
    // no coordinates without a ground hit
    a_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NOT_WHITE || status == ST_NO_HIT)
        |-> (x_m == 32'sd0) && (y_m == 32'sd0) && (z_m == 32'sd0))
        else $error("coordinates given without a ground hit");

    // depth is saturated, never negative
    a_z_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !z_m[31])
        else $error("negative depth");

    // a stalled result must not be overwritten
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(z_m) && $stable(status))
        else $error("stalled result lost");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the inverse perspective ground mapper: pixel
// requests from a queue, results checked in order against a ground-plane
// predictor, several register settings and idling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ipgm_pkg::*;

    localparam int LATENCY     = 39;
    localparam int WDOG_LIMIT  = 20000;
    localparam longint SAT_MAX = 64'd2147483647;

    typedef struct {
        logic [11:0] u;
        logic [11:0] v;
        logic [7:0]  ch [4];
        logic [2:0]  cnt;
    } pixel_t;

    typedef struct {
        logic [11:0]  u;
        logic [11:0]  v;
        logic [1:0]   st;
        logic [31:0]  x;
        logic [31:0]  y;
        logic [31:0]  z;
    } ground_pt_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [3:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [11:0] pixel_u = '0;
    logic [11:0] pixel_v = '0;
    logic [7:0] chan0 = '0, chan1 = '0, chan2 = '0, chan3 = '0;
    logic [2:0] channel_count = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [11:0] out_u, out_v;
    logic [1:0] status;
    logic signed [31:0] x_m, y_m, z_m;

    inverse_perspective_ground_map u_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the registers
    logic [31:0]        cam_inv_focal;
    logic [11:0]        cam_cx, cam_cy;
    logic [16:0]        cam_cos;
    logic signed [17:0] cam_sin;
    logic [23:0]        cam_height;
    logic [7:0]         cam_thresh;
    logic [30:0]        cam_max_dist;

    pixel_t     pixel_q [$];
    ground_pt_t ground_q [$];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  errors = 0;
    int  quiet_cycles = 0;
    logic [31:0] cfg_pend_data;
    logic [3:0]  cfg_pend_idx;
    bit          cfg_pend = 1'b0;

    function automatic void reset_shadow();
        cam_inv_focal = 32'd3976822;
        cam_cx        = 12'd960;
        cam_cy        = 12'd540;
        cam_cos       = 17'd63303;
        cam_sin       = 18'sd16962;
        cam_height    = 24'd111411;
        cam_thresh    = 8'd200;
        cam_max_dist  = 31'd13107200;
    endfunction

    function automatic void shadow_write(ipgm_reg_t idx, logic [31:0] val);
        case (idx)
            REG_INV_FOCAL:    cam_inv_focal = val;
            REG_CENTER_X:     cam_cx = val[11:0];
            REG_CENTER_Y:     cam_cy = val[11:0];
            REG_COS_PITCH:    cam_cos = val[16:0];
            REG_SIN_PITCH:    cam_sin = val[17:0];
            REG_CAM_HEIGHT:   cam_height = val[23:0];
            REG_WHITE_THRESH: cam_thresh = val[7:0];
            REG_MAX_DISTANCE: cam_max_dist = val[30:0];
            default: ;
        endcase
    endfunction

    // lateral/vertical coordinate: zs*d/2^32 toward zero, saturated
    function automatic logic [31:0] scale_ray(logic [30:0] zs, logic signed [44:0] d);
        logic [44:0] mag;
        logic [75:0] prod;
        logic [43:0] p;
        mag  = d[44] ? -d : d;
        prod = zs * mag;
        p    = prod[75:32];
        if (d[44])
        begin
            if (p > SAT_MAX + 1) p = 44'(SAT_MAX + 1);
            return -p[31:0];
        end
        if (p > SAT_MAX) p = 44'(SAT_MAX);
        return p[31:0];
    endfunction

    function automatic ground_pt_t map_pixel(pixel_t px);
        ground_pt_t r;
        int cnt;
        bit white;
        logic signed [12:0] du, dv;
        logic signed [44:0] d0, d1;
        logic [44:0] m1;
        logic [61:0] cm;
        logic signed [47:0] tt, den;
        logic [55:0] num, zq;
        logic [30:0] zs;
        r = '{px.u, px.v, ST_NOT_WHITE, 0, 0, 0};
        cnt = (px.cnt > 4) ? 4 : px.cnt;
        white = 1'b1;
        for (int i = 0; i < cnt; i++)
            if (px.ch[i] < cam_thresh) white = 1'b0;
        if (!white) return r;
        du = $signed({1'b0, px.u}) - $signed({1'b0, cam_cx});
        dv = $signed({1'b0, px.v}) - $signed({1'b0, cam_cy});
        d0 = du * $signed({1'b0, cam_inv_focal});
        d1 = dv * $signed({1'b0, cam_inv_focal});
        m1 = d1[44] ? -d1 : d1;
        cm = cam_cos * m1;
        tt = $signed({2'b00, cm[61:16]});
        den = (d1[44] ? -tt : tt) + ($signed({{30{cam_sin[17]}}, cam_sin}) <<< 16);
        if (den <= 1)
        begin
            r.st = ST_NO_HIT;
            return r;
        end
        num = {cam_height, 32'd0};
        zq  = num / {8'd0, den};
        zs  = (zq > SAT_MAX) ? 31'h7FFF_FFFF : zq[30:0];
        r.st = (zq > cam_max_dist) ? ST_TOO_FAR : ST_VALID;
        r.x = scale_ray(zs, d0);
        r.y = scale_ray(zs, d1);
        r.z = {1'b0, zs};
        return r;
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready)
            begin
                if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    pixel_t px;
                    px = pixel_q.pop_front();
                    ground_q.insert(ground_q.size(), map_pixel(px));
                    in_valid      <= 1'b1;
                    pixel_u       <= px.u;
                    pixel_v       <= px.v;
                    chan0         <= px.ch[0];
                    chan1         <= px.ch[1];
                    chan2         <= px.ch[2];
                    chan3         <= px.ch[3];
                    channel_count <= px.cnt;
                end
                else
                    in_valid <= 1'b0;
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (cfg_pend)
                begin
                    cfg_valid <= 1'b1;
                    cfg_index <= cfg_pend_idx;
                    cfg_data  <= cfg_pend_data;
                    cfg_pend  = 1'b0;
                end
                else
                    cfg_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)
                || (pixel_q.size() == 0 && !in_valid && ground_q.size() == 0))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                if (ground_q.size() == 0)
                begin
                    $error("unexpected result u=%0d v=%0d", out_u, out_v);
                    errors++;
                end
                else
                begin
                    ground_pt_t e;
                    e = ground_q.pop_front();
                    if (out_u !== e.u)
                    begin
                        $error("out_u expected %0d got %0d", e.u, out_u); errors++;
                    end
                    if (out_v !== e.v)
                    begin
                        $error("out_v expected %0d got %0d", e.v, out_v); errors++;
                    end
                    if (status !== e.st)
                    begin
                        $error("status expected %0d got %0d", e.st, status); errors++;
                    end
                    if (x_m !== e.x)
                    begin
                        $error("x_m expected %0h got %0h", e.x, x_m); errors++;
                    end
                    if (y_m !== e.y)
                    begin
                        $error("y_m expected %0h got %0h", e.y, y_m); errors++;
                    end
                    if (z_m !== e.z)
                    begin
                        $error("z_m expected %0h got %0h", e.z, z_m); errors++;
                    end
                end
            end
        end
    end

    task automatic drain();
        while (pixel_q.size() > 0 || in_valid || ground_q.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_reg(ipgm_reg_t idx, logic [31:0] val);
        shadow_write(idx, val);
        cfg_pend_idx  = idx;
        cfg_pend_data = val;
        cfg_pend      = 1'b1;
        while (cfg_pend || cfg_valid) @(posedge clk);
    endtask

    function automatic pixel_t rand_pixel(bit likely_white);
        pixel_t px;
        px.u = 12'($urandom_range(4095));
        px.v = ($urandom_range(3) == 0) ? 12'($urandom_range(4095))
                                        : 12'(cam_cy + $urandom_range(600) - 100);
        for (int i = 0; i < 4; i++)
            px.ch[i] = likely_white ? 8'($urandom_range(255, cam_thresh))
                                    : 8'($urandom_range(255));
        px.cnt = 3'($urandom_range(7));
        return px;
    endfunction

    task automatic random_batch(int n);
        for (int i = 0; i < n; i++)
            pixel_q.insert(pixel_q.size(), rand_pixel($urandom_range(3) != 0));
    endtask

    task automatic add_pixel(int u, int v, int c, int cnt);
        pixel_t px;
        px.u = 12'(u); px.v = 12'(v);
        for (int i = 0; i < 4; i++) px.ch[i] = 8'(c);
        px.cnt = 3'(cnt);
        pixel_q.insert(pixel_q.size(), px);
    endtask

    // stimulus
    initial
    begin
        reset_shadow();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, white/not white, channel counts, no hit
        add_pixel(0, 0, 255, 1);
        add_pixel(4095, 4095, 255, 4);
        add_pixel(960, 540, 255, 4);
        add_pixel(960, 1079, 200, 3);
        add_pixel(100, 600, 199, 2);
        add_pixel(100, 600, 0, 0);
        add_pixel(4095, 0, 10, 7);
        add_pixel(0, 4095, 255, 5);
        add_pixel(1500, 541, 255, 4);
        add_pixel(960, 400, 255, 4);
        begin
            pixel_t px;
            px.u = 200; px.v = 700; px.ch = '{255, 255, 255, 3}; px.cnt = 3;
            pixel_q.insert(pixel_q.size(), px);
            px.cnt = 4;
            pixel_q.insert(pixel_q.size(), px);
        end
        drain();

        // register extremes: too-far cases and saturation
        write_reg(REG_MAX_DISTANCE, 32'd0);
        write_reg(REG_CAM_HEIGHT, 32'hFF_FFFF);
        write_reg(REG_INV_FOCAL, 32'hFFFF_FFFF);
        write_reg(REG_SIN_PITCH, 32'h10000);
        write_reg(REG_COS_PITCH, 32'h10000);
        write_reg(REG_WHITE_THRESH, 32'd0);
        add_pixel(0, 0, 0, 4);
        add_pixel(4095, 4095, 0, 4);
        add_pixel(0, 4095, 0, 4);
        add_pixel(4095, 2000, 0, 1);
        add_pixel(1, 541, 0, 1);
        drain();
        write_reg(REG_SIN_PITCH, 32'h30000);
        write_reg(REG_CENTER_X, 32'd4095);
        write_reg(REG_CENTER_Y, 32'd0);
        write_reg(REG_COS_PITCH, 32'd0);
        write_reg(ipgm_reg_t'(4'd9), 32'h1234);
        add_pixel(0, 10, 0, 2);
        add_pixel(4095, 4095, 0, 2);
        drain();

        // random phases over several settings and idling mixes
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_INV_FOCAL, (ph == 0) ? 32'd3976822 : $urandom_range(32'h0400_0000));
            write_reg(REG_CENTER_X, (ph == 1) ? 0 : $urandom_range(4095));
            write_reg(REG_CENTER_Y, (ph == 2) ? 4095 : $urandom_range(300, 900));
            write_reg(REG_COS_PITCH, (ph == 3) ? 65536 : $urandom_range(40000, 65536));
            write_reg(REG_SIN_PITCH,
                      (ph == 4) ? 32'h30000 : 32'($signed($urandom_range(30000)) - 3000));
            write_reg(REG_CAM_HEIGHT, (ph == 5) ? 32'hFF_FFFF : $urandom_range(16777215));
            write_reg(REG_WHITE_THRESH, (ph == 6) ? 255 : $urandom_range(255));
            write_reg(REG_MAX_DISTANCE,
                      (ph == 7) ? 32'h7FFF_FFFF : $urandom_range(32'h0400_0000));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            random_batch(240);
            drain();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
